[sv/wrs_pkg.sv]
// ----------------------------------------------------------------------------
// wrs_pkg
// Shared types and constants of the weighted residual statistics unit.
// ----------------------------------------------------------------------------
package wrs_pkg;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// back end iterative units
	localparam int MUL_W       = 52;
	localparam int DIV_W       = 2 * MUL_W;
	localparam int SQRT_STEPS  = 32;

	localparam logic [31:0] INVALID_Q16 = 32'd65535345;
	localparam logic [39:0] ONE_SECOND  = 40'd65536;

	localparam logic RESULT_EVENT = 1'b0;
	localparam logic RESULT_DATA  = 1'b1;

	localparam logic REG_ZERO_WEIGHT  = 1'b0;
	localparam logic REG_EFF_UNKNOWNS = 1'b1;

	localparam logic [12:0] EFF_UNKNOWNS_RST = 13'd4;

	// one closed event, plus data totals when the data set ends with it
	typedef struct packed {
		logic               data_end;
		logic signed [39:0] ews;
		logic [63:0]        esq;
		logic [8:0]         ecnt;
		logic signed [51:0] tws;
		logic [63:0]        tsq;
		logic [18:0]        tcnt;
	} entry_t;

	typedef struct packed {
		logic               kind;
		logic signed [23:0] mean;
		logic [23:0]        rms;
		logic               norm;
		logic               susp;
		logic [8:0]         obs;
		logic [31:0]        dvar;
		logic [31:0]        msq;
		logic               dvalid;
		logic               last;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EV_START,
		ST_EV_MUL,
		ST_EV_DIV_S2,
		ST_EV_DIV_VAR,
		ST_EV_SQRT,
		ST_EV_DIV_MEAN,
		ST_EV_EMIT,
		ST_DT_START,
		ST_DT_MUL,
		ST_DT_DIV_S2,
		ST_DT_DIV_VAR,
		ST_DT_DIV_MSQ,
		ST_DT_EMIT
	} bst_t;

endpackage

[sv/weighted_residual_statistics_unit.sv]
// ----------------------------------------------------------------------------
// weighted_residual_statistics_unit
// Weighted residual sums per event and per data set, with normalized mean,
// standard deviation, data variance and mean square residual.
// ----------------------------------------------------------------------------
// Input side is a queue: a word (residual, weight, event_end, data_end) is
// taken when push is high and full low. Observations enter every cycle while full is low; a
// two-stage front weights and accumulates them. A word with event_end or
// data_end closes the event and hands its sums to a four-entry queue.
// Result side is a queue too: the oldest summary sits on the result ports
// while empty is low and leaves on pop. data_end yields an event summary and
// then a data summary; last marks the final one of that input word.
// The back end works on one closed event at a time, using a shared
// one-bit-per-cycle divider, a 52-step shift-add square and a 32-step square
// root; a raw event skips them, and a data summary runs the square and the
// divider again.
// A stalled receiver holds the result register, then the back end, then the
// queue fills and full rises. Reset clears all sums, the queue and the
// output valid flag; zero_weight_count resets to 0, effective_unknowns to 4.
// ----------------------------------------------------------------------------
module weighted_residual_statistics_unit import wrs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [23:0] residual,
	input  logic [17:0]        weight,
	input  logic               event_end,
	input  logic               data_end,
	output logic               empty,
	input  logic               pop,
	output logic               result_kind,
	output logic signed [23:0] event_mean,
	output logic [23:0]        event_rms,
	output logic               event_normalized,
	output logic               event_suspicious,
	output logic [8:0]         event_observations,
	output logic [31:0]        data_variance,
	output logic [31:0]        mean_square_residual,
	output logic               data_valid,
	output logic               last,
	input  logic               wr_en,
	input  logic               wr_index,
	input  logic [18:0]        wr_data
);

	logic [18:0]    zwc_q;
	logic [12:0]    eu_q;
	logic           q_push, q_pop, q_empty;
	logic [QCW-1:0] q_count;
	entry_t         q_wdata, q_rdata;
	result_t        res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zwc_q <= '0;
			eu_q  <= EFF_UNKNOWNS_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_ZERO_WEIGHT:  zwc_q <= wr_data;
				REG_EFF_UNKNOWNS: eu_q  <= wr_data[12:0];
				default: ;
			endcase
		end
	end

	wrs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.residual   (residual),
		.weight     (weight),
		.event_end  (event_end),
		.data_end   (data_end),
		.fifo_count (q_count),
		.fifo_push  (q_push),
		.fifo_entry (q_wdata)
	);

	wrs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.count  (q_count)
	);

	wrs_back u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.fifo_empty         (q_empty),
		.fifo_head          (q_rdata),
		.fifo_pop           (q_pop),
		.zero_weight_count  (zwc_q),
		.effective_unknowns (eu_q),
		.pop                (pop),
		.empty              (empty),
		.result             (res)
	);

	assign result_kind          = res.kind;
	assign event_mean           = res.mean;
	assign event_rms            = res.rms;
	assign event_normalized     = res.norm;
	assign event_suspicious     = res.susp;
	assign event_observations   = res.obs;
	assign data_variance        = res.dvar;
	assign mean_square_residual = res.msq;
	assign data_valid           = res.dvalid;
	assign last                 = res.last;

endmodule

[sv/wrs_front.sv]
// ----------------------------------------------------------------------------
// wrs_front
// Weights residuals and accumulates event and data sums; closed events go
// to the queue.
// ----------------------------------------------------------------------------
module wrs_front import wrs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [23:0] residual,
	input  logic [17:0]        weight,
	input  logic               event_end,
	input  logic               data_end,
	input  logic [QCW-1:0]     fifo_count,
	output logic               fifo_push,
	output entry_t             fifo_entry
);

	logic               valid_s1, valid_s2;
	logic signed [42:0] p_s1;
	logic               nz_s1, ev_s1, dt_s1;
	logic signed [26:0] rw_s2;
	logic [51:0]        sq_s2;
	logic               ev_s2, dt_s2;

	logic signed [39:0] ews_q;
	logic [63:0]        esq_q;
	logic [8:0]         ecnt_q;
	logic signed [51:0] tws_q;
	logic [63:0]        tsq_q;
	logic [18:0]        tcnt_q;

	logic               accept;
	logic [QCW-1:0]     pending;
	logic [41:0]        p_mag;
	logic [25:0]        m;
	logic signed [40:0] ews_sum;
	logic signed [39:0] ews_new;
	logic [64:0]        esq_sum;
	logic [63:0]        esq_new;
	logic [8:0]         ecnt_new;
	logic signed [52:0] tws_sum;
	logic signed [51:0] tws_new;
	logic [64:0]        tsq_sum;
	logic [63:0]        tsq_new;
	logic [18:0]        tcnt_new;
	logic               closes;

	// every word in flight may close an event, so reserve a slot for each
	assign pending = fifo_count + {{(QCW-1){1'b0}}, valid_s1} + {{(QCW-1){1'b0}}, valid_s2};
	assign full    = (pending >= QCW'(QDEPTH));
	assign accept  = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_s1  <= residual * $signed({1'b0, weight});
		nz_s1 <= (weight != 18'd0);
		ev_s1 <= event_end;
		dt_s1 <= data_end;
	end

	// round magnitude half away from zero
	assign p_mag = p_s1[42] ? 42'(-p_s1) : 42'(p_s1);
	assign m     = 26'((p_mag + 42'd32768) >> 16);

	always_ff @(posedge clk) begin
		if (nz_s1) begin
			rw_s2 <= p_s1[42] ? -$signed({1'b0, m}) : $signed({1'b0, m});
			sq_s2 <= m * m;
		end else begin
			rw_s2 <= '0;
			sq_s2 <= '0;
		end
		ev_s2 <= ev_s1;
		dt_s2 <= dt_s1;
	end

	always_comb begin
		ews_sum = {ews_q[39], ews_q} + {{14{rw_s2[26]}}, rw_s2};
		if (ews_sum[40] != ews_sum[39])
			ews_new = ews_sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
		else
			ews_new = ews_sum[39:0];
		esq_sum  = {1'b0, esq_q} + {13'd0, sq_s2};
		esq_new  = esq_sum[64] ? '1 : esq_sum[63:0];
		ecnt_new = (ecnt_q == '1) ? ecnt_q : ecnt_q + 9'd1;
		tcnt_new = (tcnt_q == '1) ? tcnt_q : tcnt_q + 19'd1;
		tws_sum  = {tws_q[51], tws_q} + {{13{ews_new[39]}}, ews_new};
		if (tws_sum[52] != tws_sum[51])
			tws_new = tws_sum[52] ? {1'b1, 51'd0} : {1'b0, {51{1'b1}}};
		else
			tws_new = tws_sum[51:0];
		tsq_sum = {1'b0, tsq_q} + {1'b0, esq_new};
		tsq_new = tsq_sum[64] ? '1 : tsq_sum[63:0];
	end

	assign closes    = ev_s2 || dt_s2;
	assign fifo_push = valid_s2 && closes;

	always_comb begin
		fifo_entry.data_end = dt_s2;
		fifo_entry.ews      = ews_new;
		fifo_entry.esq      = esq_new;
		fifo_entry.ecnt     = ecnt_new;
		fifo_entry.tws      = tws_new;
		fifo_entry.tsq      = tsq_new;
		fifo_entry.tcnt     = tcnt_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ews_q  <= '0;
			esq_q  <= '0;
			ecnt_q <= '0;
			tws_q  <= '0;
			tsq_q  <= '0;
			tcnt_q <= '0;
		end else if (valid_s2) begin
			if (closes) begin
				ews_q  <= '0;
				esq_q  <= '0;
				ecnt_q <= '0;
			end else begin
				ews_q  <= ews_new;
				esq_q  <= esq_new;
				ecnt_q <= ecnt_new;
			end
			if (dt_s2) begin
				tws_q  <= '0;
				tsq_q  <= '0;
				tcnt_q <= '0;
			end else begin
				tcnt_q <= tcnt_new;
				if (ev_s2) begin
					tws_q <= tws_new;
					tsq_q <= tsq_new;
				end
			end
		end
	end

endmodule

[sv/wrs_fifo.sv]
// ----------------------------------------------------------------------------
// wrs_fifo
// Short queue of closed events between front and back end.
// ----------------------------------------------------------------------------
module wrs_fifo import wrs_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  entry_t         wdata,
	input  logic           pop,
	output entry_t         rdata,
	output logic           empty,
	output logic [QCW-1:0] count
);

	entry_t         mem_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QCW-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	assign rdata = mem_q[rd_q];
	assign empty = (cnt_q == '0);
	assign count = cnt_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && cnt_q == QCW'(QDEPTH)))
		else $error("word pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && cnt_q == '0))
		else $error("word popped from empty queue");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == QCW'(QDEPTH)) || (QAW'(cnt_q) == QAW'(wr_q - rd_q)))
		else $error("queue pointers and count disagree");

endmodule

[sv/wrs_div.sv]
// ----------------------------------------------------------------------------
// wrs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wrs_div import wrs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [18:0]      divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	localparam int DIV_CW = $clog2(DIV_W);

	logic [DIV_W-1:0]  dvd_q;
	logic [18:0]       rem_q, dsr_q;
	logic [DIV_CW-1:0] cnt_q;
	logic              busy_q, done_q;
	logic [19:0]       trial;
	logic              qbit;

	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign qbit  = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? 19'(trial - {1'b0, dsr_q}) : trial[18:0];
			dvd_q <= {dvd_q[DIV_W-2:0], qbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

[sv/wrs_back.sv]
// ----------------------------------------------------------------------------
// wrs_back
// Turns closed events into event and data summaries: shift-add square,
// shared divider, bit-pair square root, one-word output register.
// ----------------------------------------------------------------------------
module wrs_back import wrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fifo_empty,
	input  entry_t      fifo_head,
	output logic        fifo_pop,
	input  logic [18:0] zero_weight_count,
	input  logic [12:0] effective_unknowns,
	input  logic        pop,
	output logic        empty,
	output result_t     result
);

	localparam int MCW = $clog2(MUL_W);
	localparam int SCW = $clog2(SQRT_STEPS);

	bst_t state_q, state_d;

	entry_t           ent_q;
	result_t          res_q, out_q;
	logic             out_valid_q;
	logic [18:0]      n_q;
	logic [MUL_W-1:0] a_q;
	logic [DIV_W-1:0] mc_q, prod_q;
	logic [MUL_W-1:0] mp_q;
	logic [MCW-1:0]   mcnt_q;
	logic [63:0]      diff_q;
	logic [63:0]      sv_q, sres_q, sbit_q;
	logic [SCW-1:0]   scnt_q;
	logic             dgo_q;

	logic             mul_init, div_start, div_done, out_load, in_div;
	logic [MUL_W-1:0] mul_a;
	logic [DIV_W-1:0] div_dvd, div_q;
	logic [18:0]      div_dsr;
	logic [39:0]      ews_mag;
	logic [51:0]      tws_mag;
	logic [19:0]      ev_d, dt_d;
	logic             ev_ok, dt_ok;
	logic [63:0]      s2_sat, sq_sel, diff_d, sroot_t;

	function automatic logic [23:0] sat_mean(input logic neg, input logic [39:0] mag);
		if (neg)
			sat_mean = (mag > 40'h800000) ? 24'h800000 : 24'(-mag[23:0]);
		else
			sat_mean = (mag > 40'h7FFFFF) ? 24'h7FFFFF : mag[23:0];
	endfunction

	function automatic logic [23:0] sat24(input logic [47:0] v);
		sat24 = (v[47:24] != '0) ? '1 : v[23:0];
	endfunction

	function automatic logic [31:0] sat32(input logic [47:0] v);
		sat32 = (v[47:32] != '0) ? '1 : v[31:0];
	endfunction

	assign ews_mag = ent_q.ews[39] ? 40'(-ent_q.ews) : 40'(ent_q.ews);
	assign tws_mag = ent_q.tws[51] ? 52'(-ent_q.tws) : 52'(ent_q.tws);
	assign ev_d    = {11'd0, ent_q.ecnt} - {1'b0, zero_weight_count};
	assign dt_d    = {1'b0, ent_q.tcnt} - {1'b0, zero_weight_count};
	assign ev_ok   = !ev_d[19] && (ev_d[18:0] > 19'd1);
	assign dt_ok   = !dt_d[19] && (dt_d[18:0] > {6'd0, effective_unknowns});

	// floor(a^2/n), held at all ones when it passes 64 bits
	assign s2_sat  = (div_q[DIV_W-1:64] != '0) ? '1 : div_q[63:0];
	assign sq_sel  = (state_q == ST_EV_DIV_S2) ? ent_q.esq : ent_q.tsq;
	assign diff_d  = (sq_sel > s2_sat) ? sq_sel - s2_sat : '0;
	assign sroot_t = sres_q + sbit_q;

	assign in_div = (state_q == ST_EV_DIV_S2) || (state_q == ST_EV_DIV_VAR) ||
	                (state_q == ST_EV_DIV_MEAN) || (state_q == ST_DT_DIV_S2) ||
	                (state_q == ST_DT_DIV_VAR) || (state_q == ST_DT_DIV_MSQ);

	wrs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		fifo_pop  = 1'b0;
		mul_init  = 1'b0;
		mul_a     = {12'd0, ews_mag};
		div_start = in_div && !dgo_q;
		div_dvd   = prod_q;
		div_dsr   = n_q;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!fifo_empty) begin
					fifo_pop = 1'b1;
					state_d  = ST_EV_START;
				end
			end
			ST_EV_START: begin
				if (ev_ok) begin
					mul_init = 1'b1;
					state_d  = ST_EV_MUL;
				end else begin
					state_d = ST_EV_EMIT;
				end
			end
			ST_EV_MUL: begin
				if (mcnt_q == MCW'(MUL_W - 1))
					state_d = ST_EV_DIV_S2;
			end
			ST_EV_DIV_S2: begin
				if (div_done)
					state_d = ST_EV_DIV_VAR;
			end
			ST_EV_DIV_VAR: begin
				div_dvd = {{(DIV_W-64){1'b0}}, diff_q};
				div_dsr = n_q - 19'd1;
				if (div_done)
					state_d = ST_EV_SQRT;
			end
			ST_EV_SQRT: begin
				if (scnt_q == SCW'(SQRT_STEPS - 1))
					state_d = ST_EV_DIV_MEAN;
			end
			ST_EV_DIV_MEAN: begin
				div_dvd = {{(DIV_W-MUL_W){1'b0}}, a_q};
				if (div_done)
					state_d = ST_EV_EMIT;
			end
			ST_EV_EMIT: begin
				if (!out_valid_q || pop) begin
					out_load = 1'b1;
					state_d  = ent_q.data_end ? ST_DT_START : ST_IDLE;
				end
			end
			ST_DT_START: begin
				mul_a = tws_mag;
				if (dt_ok) begin
					mul_init = 1'b1;
					state_d  = ST_DT_MUL;
				end else begin
					state_d = ST_DT_EMIT;
				end
			end
			ST_DT_MUL: begin
				if (mcnt_q == MCW'(MUL_W - 1))
					state_d = ST_DT_DIV_S2;
			end
			ST_DT_DIV_S2: begin
				if (div_done)
					state_d = ST_DT_DIV_VAR;
			end
			ST_DT_DIV_VAR: begin
				div_dvd = {{(DIV_W-64){1'b0}}, diff_q};
				div_dsr = n_q - {6'd0, effective_unknowns};
				if (div_done)
					state_d = ST_DT_DIV_MSQ;
			end
			ST_DT_DIV_MSQ: begin
				div_dvd = {{(DIV_W-64){1'b0}}, diff_q};
				if (div_done)
					state_d = ST_DT_EMIT;
			end
			ST_DT_EMIT: begin
				if (!out_valid_q || pop) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dgo_q       <= 1'b0;
			out_valid_q <= 1'b0;
			mcnt_q      <= '0;
			scnt_q      <= '0;
		end else begin
			if (div_start)
				dgo_q <= 1'b1;
			else if (div_done)
				dgo_q <= 1'b0;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			if (mul_init)
				mcnt_q <= '0;
			else if (state_q == ST_EV_MUL || state_q == ST_DT_MUL)
				mcnt_q <= mcnt_q + 1'b1;
			if (state_q == ST_EV_DIV_VAR && div_done)
				scnt_q <= '0;
			else if (state_q == ST_EV_SQRT)
				scnt_q <= scnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fifo_pop)
			ent_q <= fifo_head;

		// shift-add square of the sum magnitude
		if (mul_init) begin
			a_q    <= mul_a;
			mc_q   <= {{(DIV_W-MUL_W){1'b0}}, mul_a};
			mp_q   <= mul_a;
			prod_q <= '0;
		end else if (state_q == ST_EV_MUL || state_q == ST_DT_MUL) begin
			if (mp_q[0])
				prod_q <= prod_q + mc_q;
			mc_q <= {mc_q[DIV_W-2:0], 1'b0};
			mp_q <= {1'b0, mp_q[MUL_W-1:1]};
		end

		if ((state_q == ST_EV_DIV_S2 || state_q == ST_DT_DIV_S2) && div_done)
			diff_q <= diff_d;

		// bit-pair integer square root
		if (state_q == ST_EV_DIV_VAR && div_done) begin
			sv_q   <= div_q[63:0];
			sres_q <= '0;
			sbit_q <= 64'h4000_0000_0000_0000;
		end else if (state_q == ST_EV_SQRT) begin
			if (sv_q >= sroot_t) begin
				sv_q   <= sv_q - sroot_t;
				sres_q <= (sres_q >> 1) + sbit_q;
			end else begin
				sres_q <= sres_q >> 1;
			end
			sbit_q <= sbit_q >> 2;
		end

		case (state_q)
			ST_EV_START: begin
				n_q          <= ev_d[18:0];
				res_q.kind   <= RESULT_EVENT;
				res_q.obs    <= ent_q.ecnt;
				res_q.dvar   <= '0;
				res_q.msq    <= '0;
				res_q.dvalid <= 1'b0;
				res_q.last   <= !ent_q.data_end;
				res_q.norm   <= ev_ok;
				res_q.mean   <= sat_mean(ent_q.ews[39], ews_mag);
				res_q.rms    <= sat24(ent_q.esq[63:16]);
				res_q.susp   <= (ews_mag > ONE_SECOND);
			end
			ST_EV_DIV_MEAN: begin
				if (div_done) begin
					res_q.mean <= sat_mean(ent_q.ews[39], div_q[39:0]);
					res_q.rms  <= sat24(sres_q[47:0]);
					res_q.susp <= (div_q[39:0] > ONE_SECOND);
				end
			end
			ST_DT_START: begin
				n_q          <= dt_d[18:0];
				res_q.kind   <= RESULT_DATA;
				res_q.mean   <= '0;
				res_q.rms    <= '0;
				res_q.norm   <= 1'b0;
				res_q.susp   <= 1'b0;
				res_q.obs    <= '0;
				res_q.last   <= 1'b1;
				res_q.dvalid <= dt_ok;
				res_q.dvar   <= INVALID_Q16;
				res_q.msq    <= INVALID_Q16;
			end
			ST_DT_DIV_VAR: begin
				if (div_done)
					res_q.dvar <= sat32(div_q[63:16]);
			end
			ST_DT_DIV_MSQ: begin
				if (div_done)
					res_q.msq <= sat32(div_q[63:16]);
			end
			default: ;
		endcase

		if (out_load)
			out_q <= res_q;
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

	a_pop_idle_only: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_pop |-> (state_q == ST_IDLE))
		else $error("queue read outside idle");

	a_div_one_job: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !dgo_q)
		else $error("divider restarted while running");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || pop))
		else $error("output register overwritten");

endmodule
